FILE: src/counting_semaphore_waiter_select_assert.svh
// ----------------------------------------------------------------------------
// Counting semaphore assertion macros
// Macros for the concurrent checks of the semaphore; empty when SYNTH is set.
// ----------------------------------------------------------------------------
`ifndef COUNTING_SEMAPHORE_WAITER_SELECT_ASSERT_SVH
`define COUNTING_SEMAPHORE_WAITER_SELECT_ASSERT_SVH

`ifndef SYNTH

// Same-cycle implication under reset.
`define CSWS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("semaphore check failed");

// Next-cycle implication under reset.
`define CSWS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("semaphore check failed");

`else

`define CSWS_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define CSWS_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

FILE: src/csws_pkg.sv
// ----------------------------------------------------------------------------
// Counting semaphore package
// Sizes, codes and the sequencer state type shared by the semaphore files.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package csws_pkg;

    // Waiter table size and derived widths.
    localparam int MAX_WAITERS = 16;
    localparam int IDX_W       = (MAX_WAITERS > 1) ? $clog2(MAX_WAITERS) : 1;
    localparam int CNT_W       = $clog2(MAX_WAITERS + 1);

    // Item field widths.
    localparam int TID_W   = 6;
    localparam int RUN_W   = 32;
    localparam int COUNT_W = 16;
    localparam int INIT_W  = 15;
    localparam int ENTRY_W = TID_W + RUN_W;

    // Configuration port.
    localparam int APB_DW = 32;
    localparam int APB_AW = 3;
    localparam logic REG_INITIAL_COUNT = 1'b0;

    // Operation codes.
    localparam logic OP_WAIT   = 1'b0;
    localparam logic OP_SIGNAL = 1'b1;

    // Count limits.
    localparam logic signed [COUNT_W-1:0] COUNT_MAX = 16'sh7FFF;
    localparam logic signed [COUNT_W-1:0] COUNT_MIN = 16'sh8000;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FINISH,
        ST_SCAN,
        ST_SHIFT
    } t_state;

endpackage

FILE: src/csws_ram.sv
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module csws_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                          i_clk,
    input  logic                                          i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                              i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                              o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: src/counting_semaphore_waiter_select.sv
// ----------------------------------------------------------------------------
// Counting semaphore with priority wakeup
// A wait decrements the count and queues the thread when it goes negative; a
// signal increments it and wakes the queued thread with the lowest run count.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low, and busy stays high
// until its result has been produced. The result appears on the o_ ports for
// exactly one cycle with o_valid high, and the receiver cannot stall it. A
// wait, or a signal with no waiters held, passes through the finish state
// before its result is given. A signal with waiters held scans the table
// through the single read port of the waiter RAM and then shifts the later
// entries down through the same port. In every case the result appears in
// the same cycle as busy falls. A write of initial_count reloads the count
// and empties the table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "counting_semaphore_waiter_select_assert.svh"

module counting_semaphore_waiter_select
    import csws_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // Command channel
    input  logic                      start,
    output logic                      busy,
    input  logic                      i_opcode,
    input  logic [TID_W-1:0]          i_thread_id,
    input  logic [RUN_W-1:0]          i_run_count,
    // Result channel
    output logic                      o_valid,
    output logic                      o_blocked,
    output logic                      o_woken_valid,
    output logic [TID_W-1:0]          o_woken_id,
    output logic signed [COUNT_W-1:0] o_count_value,
    output logic                      o_overflow,
    // Configuration port
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [APB_AW-1:0]         paddr,
    input  logic [APB_DW-1:0]         pwdata,
    output logic [APB_DW-1:0]         prdata,
    output logic                      pready
);

    t_state r_state, n_state;

    logic                      r_op, n_op;
    logic [TID_W-1:0]          r_tid, n_tid;
    logic [RUN_W-1:0]          r_rc, n_rc;
    logic signed [COUNT_W-1:0] r_count, n_count;
    logic [INIT_W-1:0]         r_init;
    logic [CNT_W-1:0]          r_total, n_total;
    logic [CNT_W-1:0]          r_idx, n_idx;
    logic                      r_rvalid, n_rvalid;
    logic [IDX_W-1:0]          r_ridx, n_ridx;
    logic [IDX_W-1:0]          r_best, n_best;
    logic [RUN_W-1:0]          r_best_rc, n_best_rc;
    logic [TID_W-1:0]          r_best_id, n_best_id;

    logic                      r_o_valid, n_o_valid;
    logic                      r_o_blocked, n_o_blocked;
    logic                      r_o_woken_valid, n_o_woken_valid;
    logic [TID_W-1:0]          r_o_woken_id, n_o_woken_id;
    logic signed [COUNT_W-1:0] r_o_count, n_o_count;
    logic                      r_o_overflow, n_o_overflow;

    logic                      accept;
    logic                      cfg_wr;
    logic                      scan_issue;
    logic                      shift_issue;
    logic                      scan_last;
    logic                      shift_done;
    logic                      take;

    logic                      ram_we;
    logic [IDX_W-1:0]          ram_waddr;
    logic [ENTRY_W-1:0]        ram_wdata;
    logic [IDX_W-1:0]          ram_raddr;
    logic [ENTRY_W-1:0]        ram_rdata;
    logic [TID_W-1:0]          rd_id;
    logic [RUN_W-1:0]          rd_rc;

    // Waiter table: thread id above run count in each entry.
    csws_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_WAITERS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign rd_id = ram_rdata[ENTRY_W-1:RUN_W];
    assign rd_rc = ram_rdata[RUN_W-1:0];

    // Handshake and configuration decode.
    assign busy   = (r_state != ST_IDLE);
    assign accept = start && !busy;
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready &&
                    (paddr[APB_AW-1] == REG_INITIAL_COUNT);
    assign prdata = (paddr[APB_AW-1] == REG_INITIAL_COUNT) ?
                    {{(APB_DW - INIT_W){1'b0}}, r_init} : '0;

    // Table walk conditions.
    assign scan_issue  = (r_state == ST_SCAN) && (r_idx < r_total);
    assign shift_issue = (r_state == ST_SHIFT) && (r_idx < r_total);
    assign scan_last   = (r_state == ST_SCAN) && r_rvalid &&
                         ({{(CNT_W - IDX_W){1'b0}}, r_ridx} == (r_total - 1'b1));
    assign shift_done  = (r_state == ST_SHIFT) && (r_idx >= r_total);
    assign take        = (r_state == ST_SCAN) && r_rvalid &&
                         ((r_ridx == '0) || (rd_rc < r_best_rc));

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if ((i_opcode == OP_SIGNAL) && (r_total != '0)) begin
                        n_state = ST_SCAN;
                    end else begin
                        n_state = ST_FINISH;
                    end
                end
            end
            ST_FINISH: begin
                n_state = ST_IDLE;
            end
            ST_SCAN: begin
                if (scan_last) begin
                    n_state = ST_SHIFT;
                end
            end
            ST_SHIFT: begin
                if (shift_done) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Datapath, table port control and result formation.
    always_comb begin
        n_op            = r_op;
        n_tid           = r_tid;
        n_rc            = r_rc;
        n_count         = r_count;
        n_total         = r_total;
        n_idx           = r_idx;
        n_rvalid        = scan_issue || shift_issue;
        n_ridx          = r_idx[IDX_W-1:0];
        n_best          = r_best;
        n_best_rc       = r_best_rc;
        n_best_id       = r_best_id;
        n_o_valid       = 1'b0;
        n_o_blocked     = r_o_blocked;
        n_o_woken_valid = r_o_woken_valid;
        n_o_woken_id    = r_o_woken_id;
        n_o_count       = r_o_count;
        n_o_overflow    = r_o_overflow;
        ram_we          = 1'b0;
        ram_waddr       = r_total[IDX_W-1:0];
        ram_wdata       = {r_tid, r_rc};
        ram_raddr       = r_idx[IDX_W-1:0];

        case (r_state)
            ST_IDLE: begin
                // Capture the item and apply the saturating count step.
                if (accept) begin
                    n_op  = i_opcode;
                    n_tid = i_thread_id;
                    n_rc  = i_run_count;
                    n_idx = '0;
                    if (i_opcode == OP_WAIT) begin
                        if (r_count != COUNT_MIN) begin
                            n_count = r_count - 16'sd1;
                        end
                    end else begin
                        if (r_count != COUNT_MAX) begin
                            n_count = r_count + 16'sd1;
                        end
                    end
                end
            end
            ST_FINISH: begin
                // Wait, or signal with an empty table.
                n_o_valid       = 1'b1;
                n_o_blocked     = 1'b0;
                n_o_woken_valid = 1'b0;
                n_o_woken_id    = '0;
                n_o_count       = r_count;
                n_o_overflow    = 1'b0;
                if ((r_op == OP_WAIT) && r_count[COUNT_W-1]) begin
                    if (r_total < CNT_W'(MAX_WAITERS)) begin
                        ram_we      = 1'b1;
                        n_total     = r_total + 1'b1;
                        n_o_blocked = 1'b1;
                    end else begin
                        n_o_overflow = 1'b1;
                    end
                end
            end
            ST_SCAN: begin
                // One entry read per cycle; the earliest minimum is kept.
                if (scan_issue) begin
                    n_idx = r_idx + 1'b1;
                end
                if (take) begin
                    n_best    = r_ridx;
                    n_best_rc = rd_rc;
                    n_best_id = rd_id;
                end
                if (scan_last) begin
                    n_idx = {{(CNT_W - IDX_W){1'b0}}, n_best} + 1'b1;
                end
            end
            ST_SHIFT: begin
                // Read entry i + 1 and write it back at i on the next cycle.
                if (shift_issue) begin
                    n_idx = r_idx + 1'b1;
                end
                if (r_rvalid) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_ridx - 1'b1;
                    ram_wdata = ram_rdata;
                end
                if (shift_done) begin
                    n_total         = r_total - 1'b1;
                    n_o_valid       = 1'b1;
                    n_o_blocked     = 1'b0;
                    n_o_woken_valid = 1'b1;
                    n_o_woken_id    = r_best_id;
                    n_o_count       = r_count;
                    n_o_overflow    = 1'b0;
                end
            end
            default: begin
                n_rvalid = 1'b0;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_init    <= '0;
            r_count   <= '0;
            r_total   <= '0;
            r_rvalid  <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_rvalid  <= n_rvalid;
            r_o_valid <= n_o_valid;
            if (cfg_wr) begin
                r_init  <= pwdata[INIT_W-1:0];
                r_count <= {1'b0, pwdata[INIT_W-1:0]};
                r_total <= '0;
            end else begin
                r_count <= n_count;
                r_total <= n_total;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_op            <= n_op;
        r_tid           <= n_tid;
        r_rc            <= n_rc;
        r_idx           <= n_idx;
        r_ridx          <= n_ridx;
        r_best          <= n_best;
        r_best_rc       <= n_best_rc;
        r_best_id       <= n_best_id;
        r_o_blocked     <= n_o_blocked;
        r_o_woken_valid <= n_o_woken_valid;
        r_o_woken_id    <= n_o_woken_id;
        r_o_count       <= n_o_count;
        r_o_overflow    <= n_o_overflow;
    end

    assign o_valid       = r_o_valid;
    assign o_blocked     = r_o_blocked;
    assign o_woken_valid = r_o_woken_valid;
    assign o_woken_id    = r_o_woken_id;
    assign o_count_value = r_o_count;
    assign o_overflow    = r_o_overflow;

    // Checks on the sequencer and the table occupancy.
    `CSWS_ASSERT_NOW(a_total_bound, i_clk, i_rst_n, 1'b1, r_total <= CNT_W'(MAX_WAITERS))
    `CSWS_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, accept, busy)
    `CSWS_ASSERT_NOW(a_write_active, i_clk, i_rst_n, ram_we, r_state != ST_IDLE)
    `CSWS_ASSERT_NEXT(a_wake_pops, i_clk, i_rst_n, shift_done && !cfg_wr, r_total == $past(r_total) - 1'b1)

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Counting semaphore testbench
// Drives wait and signal items into the semaphore with bursty timing, reloads
// the count through the register port between phases, and checks every result
// against a cycle-free predictor of the count and the waiter table.
// ----------------------------------------------------------------------------

module tb_top;

    import csws_pkg::*;

    typedef enum logic [1:0] {
        CMD_OP,
        CMD_LOAD,
        CMD_SETTLE
    } cmd_kind_t;

    typedef enum logic [1:0] {
        APB_IDLE,
        APB_SETUP,
        APB_ACCESS
    } apb_phase_t;

    typedef struct {
        cmd_kind_t          kind;
        logic               opcode;
        logic [TID_W-1:0]   tid;
        logic [RUN_W-1:0]   run;
        logic [INIT_W-1:0]  load;
    } sem_cmd_t;

    typedef struct packed {
        logic               blocked;
        logic               woken_valid;
        logic [TID_W-1:0]   woken_id;
        logic [COUNT_W-1:0] count_value;
        logic               overflow;
    } sem_result_t;

    typedef struct {
        logic [TID_W-1:0] tid;
        logic [RUN_W-1:0] run;
    } waiter_t;

    // Block ports; every input starts at a known value.
    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      start = 1'b0;
    logic                      busy;
    logic                      i_opcode = OP_WAIT;
    logic [TID_W-1:0]          i_thread_id = '0;
    logic [RUN_W-1:0]          i_run_count = '0;
    logic                      o_valid;
    logic                      o_blocked;
    logic                      o_woken_valid;
    logic [TID_W-1:0]          o_woken_id;
    logic signed [COUNT_W-1:0] o_count_value;
    logic                      o_overflow;
    logic                      psel = 1'b0;
    logic                      penable = 1'b0;
    logic                      pwrite = 1'b0;
    logic [APB_AW-1:0]         paddr = '0;
    logic [APB_DW-1:0]         pwdata = '0;
    logic [APB_DW-1:0]         prdata;
    logic                      pready;

    // Predicted semaphore state.
    logic signed [COUNT_W-1:0] model_count = '0;
    waiter_t                   waiter_table[$];

    // Commands still to be driven and results still to arrive.
    sem_cmd_t                  cmd_queue[$];
    sem_result_t               results_due[$];

    sem_cmd_t                  presented;
    apb_phase_t                apb_phase = APB_IDLE;
    int                        burst_left = 8;
    int                        gap_left = 0;
    int                        error_count = 0;
    int                        ops_queued = 0;

    counting_semaphore_waiter_select dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_opcode      (i_opcode),
        .i_thread_id   (i_thread_id),
        .i_run_count   (i_run_count),
        .o_valid       (o_valid),
        .o_blocked     (o_blocked),
        .o_woken_valid (o_woken_valid),
        .o_woken_id    (o_woken_id),
        .o_count_value (o_count_value),
        .o_overflow    (o_overflow),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // Applies one wait or signal to the predicted state and returns its result.
    function automatic sem_result_t apply_semaphore_op(input sem_cmd_t c);
        sem_result_t r;
        waiter_t     w;
        int          best;
        r = '0;
        if (c.opcode == OP_WAIT) begin
            if (model_count != COUNT_MIN) begin
                model_count = model_count - 1;
            end
            if (model_count < 0) begin
                if (waiter_table.size() < MAX_WAITERS) begin
                    w.tid = c.tid;
                    w.run = c.run;
                    waiter_table.push_back(w);
                    r.blocked = 1'b1;
                end else begin
                    r.overflow = 1'b1;
                end
            end
        end else begin
            if (model_count != COUNT_MAX) begin
                model_count = model_count + 1;
            end
            if (waiter_table.size() > 0) begin
                // Lowest run count wins; a strict compare keeps the earliest on ties.
                best = 0;
                for (int i = 1; i < waiter_table.size(); i++) begin
                    if (waiter_table[i].run < waiter_table[best].run) begin
                        best = i;
                    end
                end
                r.woken_valid = 1'b1;
                r.woken_id = waiter_table[best].tid;
                waiter_table.delete(best);
            end
        end
        r.count_value = model_count;
        return r;
    endfunction

    // Run counts lean towards the extremes and a few small values so ties occur.
    function automatic logic [RUN_W-1:0] pick_run();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            2, 3: return RUN_W'($urandom_range(0, 3));
            default: return RUN_W'($urandom);
        endcase
    endfunction

    task automatic push_op(input logic opcode, input logic [TID_W-1:0] tid,
                           input logic [RUN_W-1:0] run);
        sem_cmd_t c;
        c.kind = CMD_OP;
        c.opcode = opcode;
        c.tid = tid;
        c.run = run;
        c.load = '0;
        cmd_queue.push_back(c);
        ops_queued++;
    endtask

    task automatic push_random_op(input logic opcode);
        push_op(opcode, TID_W'($urandom_range(0, 63)), pick_run());
    endtask

    task automatic push_load(input logic [INIT_W-1:0] value);
        sem_cmd_t c;
        c.kind = CMD_LOAD;
        c.opcode = OP_WAIT;
        c.tid = '0;
        c.run = '0;
        c.load = value;
        cmd_queue.push_back(c);
    endtask

    task automatic push_settle();
        sem_cmd_t c;
        c.kind = CMD_SETTLE;
        c.opcode = OP_WAIT;
        c.tid = '0;
        c.run = '0;
        c.load = '0;
        cmd_queue.push_back(c);
    endtask

    // Clock.
    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // Command driver: presents items in bursts and performs register writes
    // only once the block has gone quiet.
    always @(posedge i_clk) begin : drive_cmds
        sem_result_t due;
        if (!i_rst_n) begin
            start <= 1'b0;
            psel <= 1'b0;
            penable <= 1'b0;
            pwrite <= 1'b0;
        end else begin
            // An item taken at this edge has its result predicted now.
            if (start && !busy) begin
                due = apply_semaphore_op(presented);
                results_due.push_back(due);
            end

            if (apb_phase == APB_ACCESS) begin
                if (psel && penable && pwrite && pready) begin
                    // The write reloads the count and empties the table.
                    model_count = COUNT_W'(pwdata[INIT_W-1:0]);
                    waiter_table.delete();
                    psel <= 1'b0;
                    penable <= 1'b0;
                    pwrite <= 1'b0;
                    apb_phase = APB_IDLE;
                end
            end else if (apb_phase == APB_SETUP) begin
                penable <= 1'b1;
                apb_phase = APB_ACCESS;
            end else if (start && busy) begin
                // Hold the item until the block takes it.
            end else if (gap_left > 0) begin
                start <= 1'b0;
                gap_left--;
            end else if (cmd_queue.size() == 0) begin
                start <= 1'b0;
            end else if (cmd_queue[0].kind == CMD_OP) begin
                presented = cmd_queue.pop_front();
                start <= 1'b1;
                i_opcode <= presented.opcode;
                i_thread_id <= presented.tid;
                i_run_count <= presented.run;
                burst_left--;
                if (burst_left <= 0) begin
                    burst_left = $urandom_range(1, 24);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                end
            end else if (results_due.size() == 0 && !o_valid && !busy && !start) begin
                // Everything outstanding has come back, so the block is idle.
                if (cmd_queue[0].kind == CMD_LOAD) begin
                    psel <= 1'b1;
                    penable <= 1'b0;
                    pwrite <= 1'b1;
                    paddr <= APB_AW'(4 * int'(REG_INITIAL_COUNT));
                    pwdata <= APB_DW'(cmd_queue[0].load);
                    apb_phase = APB_SETUP;
                end
                void'(cmd_queue.pop_front());
                start <= 1'b0;
            end else begin
                start <= 1'b0;
            end
        end
    end

    // Result monitor: each strobed result is matched against the oldest prediction.
    always @(posedge i_clk) begin : check_results
        sem_result_t want;
        sem_result_t got;
        if (i_rst_n && o_valid) begin
            got = {o_blocked, o_woken_valid, o_woken_id, o_count_value, o_overflow};
            if (results_due.size() == 0) begin
                error_count++;
                if (error_count <= 10) begin
                    $display("unexpected result: blocked=%0d woken=%0d id=%0d count=%0d ovf=%0d",
                             got.blocked, got.woken_valid, got.woken_id,
                             $signed(got.count_value), got.overflow);
                end
            end else begin
                want = results_due.pop_front();
                if (got !== want) begin
                    error_count++;
                    if (error_count <= 10) begin
                        $display("mismatch: expected blocked=%0d woken=%0d id=%0d count=%0d ovf=%0d",
                                 want.blocked, want.woken_valid, want.woken_id,
                                 $signed(want.count_value), want.overflow);
                        $display("          got      blocked=%0d woken=%0d id=%0d count=%0d ovf=%0d",
                                 got.blocked, got.woken_valid, got.woken_id,
                                 $signed(got.count_value), got.overflow);
                    end
                end
            end
        end
    end

    // Stimulus, reset and end of run.
    initial begin : run_test
        int n_wait;
        int n_sig;
        int random_from;

        // Directed: extreme fields, ties and wake order from a zero count.
        push_load(0);
        push_op(OP_WAIT, 6'd63, 32'hFFFF_FFFF);
        push_op(OP_WAIT, 6'd0, 32'h0000_0000);
        push_op(OP_WAIT, 6'd21, 32'hAAAA_AAAA);
        push_op(OP_WAIT, 6'd42, 32'h5555_5555);
        push_op(OP_WAIT, 6'd5, 32'h0000_0000);
        push_op(OP_SIGNAL, 6'd63, 32'hFFFF_FFFF);
        repeat (4) push_random_op(OP_SIGNAL);
        // Signal with no waiters left only moves the count.
        push_op(OP_SIGNAL, 6'd0, 32'h0000_0000);
        // Count at its upper limit stays there on signal.
        push_settle();
        push_load(15'h7FFF);
        push_random_op(OP_SIGNAL);
        push_random_op(OP_WAIT);
        // Crossing zero from a count of one.
        push_load(15'd1);
        push_random_op(OP_WAIT);
        push_random_op(OP_WAIT);
        push_random_op(OP_SIGNAL);

        // Random phases: mostly runs of waits followed by signals, some noise.
        random_from = ops_queued;
        while (ops_queued - random_from < 400) begin
            push_settle();
            case ($urandom_range(0, 7))
                0: push_load(15'h7FFF);
                1: push_load(INIT_W'($urandom_range(0, 32767)));
                2: push_load('0);
                default: push_load(INIT_W'($urandom_range(0, 3)));
            endcase
            repeat ($urandom_range(2, 5)) begin
                if ($urandom_range(0, 4) == 0) begin
                    repeat ($urandom_range(1, 6)) push_random_op(1'($urandom_range(0, 1)));
                end else begin
                    n_wait = $urandom_range(1, 20);
                    n_sig = $urandom_range(0, n_wait + 2);
                    repeat (n_wait) push_random_op(OP_WAIT);
                    repeat (n_sig) push_random_op(OP_SIGNAL);
                end
            end
        end

        // Single reset at the start of the run.
        i_rst_n = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (cmd_queue.size() != 0 || start || apb_phase != APB_IDLE
               || results_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (40) @(posedge i_clk);

        if (results_due.size() != 0) begin
            $display("%0d predicted results never arrived", results_due.size());
        end
        if (error_count == 0 && results_due.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // Watchdog.
    initial begin
        #15_000_000;
        $display("timeout waiting for the block");
        $display("== FAIL ==");
        $finish;
    end

endmodule
